>>> rtl/tsfb_pkg.sv
// Package for the tempo system-exclusive frame builder.
// Holds frame constants, the header table and the CRC-8 byte function; no dependencies.
`default_nettype none
package tsfb_pkg;
  localparam int unsigned HdrLen   = 13;
  localparam int unsigned FrameLen = 38;
  localparam logic [7:0]  SoxByte  = 8'hF0;
  localparam logic [7:0]  EoxByte  = 8'hF7;
  localparam logic [7:0]  CrcPoly  = 8'h07;

  typedef logic [5:0] idx_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = 8'h01;
      4'd2:    b = 8'h0E;
      4'd3:    b = 8'h11;
      4'd4:    b = 8'h48;
      4'd5:    b = 8'h07;
      4'd9:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

>>> rtl/tempo_sysex_frame_builder_top.sv
// Top level of the tempo system-exclusive frame builder.
// Depends on tsfb_pkg for constants, the header table and the CRC function.
//
// Use: drive tempo_ms_i and raise start_i while busy_o is low; the item is
// taken at that clock edge. On the next cycle the 38 frame bytes begin to
// appear on frame_byte_o, one per cycle, each marked by valid_o for one cycle,
// with last_o high on the closing 0xF7 byte.
// An item occupies the block while the byte counter walks the frame.
// busy_o is low during the last byte, so the next item may be accepted then
// and its frame follows without a gap.
// On acceptance the tempo is converted to its single-precision pattern and
// the payload CRC is formed; the constant header's CRC is folded in by the
// same logic but reduces to a constant at synthesis, leaving four byte steps.
// Reset clears the counter and the strobe; the receiver cannot stall, so
// every byte is taken in the cycle it is shown.
`default_nettype none
module tempo_sysex_frame_builder_top
  import tsfb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [9:0] tempo_ms_i,
  output logic            valid_o,
  output logic [7:0]      frame_byte_o,
  output logic            last_o
);
  logic        active_q;
  idx_t        idx_q, idx_d;
  logic [31:0] bits_q, bits_d;
  logic [7:0]  crc_q, crc_d;
  logic        accept;
  logic [3:0]  msb;
  logic [7:0]  pay;
  logic [4:0]  pidx;

  assign busy_o = active_q && (idx_q != idx_t'(FrameLen - 1));
  assign accept = start_i && !busy_o;

  // Integer to single precision: exact, as every 10-bit value fits the mantissa.
  always_comb begin
    logic [22:0] man;
    logic [31:0] b;
    logic [7:0]  c;
    msb = '0;
    for (int k = 0; k < 10; k++) begin
      if (tempo_ms_i[k]) msb = 4'(k);
    end
    man = {tempo_ms_i, 13'd0} << (4'd10 - msb);
    b = (tempo_ms_i == '0) ? 32'd0 : {1'b0, 8'd127 + {4'd0, msb}, man};
    bits_d = b;
    c = 8'd0;
    for (int i = 0; i < HdrLen; i++) c = crc8_byte(c, hdr_byte(4'(i)));
    for (int i = 0; i < 4; i++) c = crc8_byte(c, b[8*i +: 8]);
    crc_d = c;
  end

  assign idx_d = accept ? '0 : idx_q + 6'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (accept) active_q <= 1'b1;
      else if (active_q && idx_q == idx_t'(FrameLen - 1)) active_q <= 1'b0;
      if (accept || active_q) idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q <= bits_d;
      crc_q  <= crc_d;
    end
  end

  // Bytes 3 to 36 are payload nibbles; payload byte index is (idx-3)/2.
  // The float bytes sit at payload indices 13 to 16, so the byte lane is the
  // index minus one, taken modulo four.
  always_comb begin
    logic [5:0] off;
    logic [1:0] bsel;
    off  = idx_q - 6'd3;
    pidx = off[5:1];
    bsel = pidx[1:0] - 2'd1;
    if (pidx < 5'(HdrLen)) pay = hdr_byte(pidx[3:0]);
    else                   pay = bits_q[{bsel, 3'b000} +: 8];
    if (idx_q == '0)                            frame_byte_o = SoxByte;
    else if (idx_q == 6'd1)                     frame_byte_o = {4'd0, crc_q[7:4]};
    else if (idx_q == 6'd2)                     frame_byte_o = {4'd0, crc_q[3:0]};
    else if (idx_q == idx_t'(FrameLen - 1))     frame_byte_o = EoxByte;
    else if (!off[0])                           frame_byte_o = {4'd0, pay[7:4]};
    else                                        frame_byte_o = {4'd0, pay[3:0]};
  end

  assign valid_o = active_q;
  assign last_o  = active_q && (idx_q == idx_t'(FrameLen - 1));
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the tempo system-exclusive frame builder.
// Depends on tsfb_pkg for frame constants and on tempo_sysex_frame_builder_top.
`timescale 1ns / 100ps

module tb_top;
  import tsfb_pkg::*;

  // Scoreboard: predicts the frame bytes of each accepted tempo item and
  // checks each strobed byte against the oldest expected one.
  class frame_scoreboard;
    logic [7:0] exp_bytes[$];
    logic       exp_last[$];
    int         errors;
    int         bytes_seen;

    // Exact integer to single-precision conversion; every 10-bit value fits.
    function automatic logic [31:0] tempo_to_single(logic [9:0] v);
      int msb;
      logic [31:0] m;
      msb = 0;
      if (v == 0) return 32'h0;
      for (int k = 0; k < 10; k++) if (v[k]) msb = k;
      m = (32'(v) << (23 - msb)) & 32'h007F_FFFF;
      return ((32'd127 + 32'(msb)) << 23) | m;
    endfunction

    function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
      return c;
    endfunction

    function void note_tempo(logic [9:0] tempo);
      logic [7:0] hdr[13];
      logic [7:0] payload[17];
      logic [31:0] bits;
      logic [7:0] crc;
      hdr = '{8'h01, 8'h00, 8'h0E, 8'h11, 8'h48, 8'h07, 8'h00,
              8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
      bits = tempo_to_single(tempo);
      crc = 8'h00;
      for (int i = 0; i < 13; i++) payload[i] = hdr[i];
      for (int i = 0; i < 4; i++) payload[13 + i] = bits[8*i +: 8];
      for (int i = 0; i < 17; i++) crc = crc_step(crc, payload[i]);
      exp_bytes.push_back(SoxByte);          exp_last.push_back(1'b0);
      exp_bytes.push_back({4'h0, crc[7:4]}); exp_last.push_back(1'b0);
      exp_bytes.push_back({4'h0, crc[3:0]}); exp_last.push_back(1'b0);
      for (int i = 0; i < 17; i++) begin
        exp_bytes.push_back({4'h0, payload[i][7:4]}); exp_last.push_back(1'b0);
        exp_bytes.push_back({4'h0, payload[i][3:0]}); exp_last.push_back(1'b0);
      end
      exp_bytes.push_back(EoxByte);          exp_last.push_back(1'b1);
    endfunction

    function void check_byte(logic [7:0] fb, logic lst);
      logic [7:0] eb;
      logic el;
      bytes_seen++;
      if (exp_bytes.size() == 0) begin
        $error("unexpected frame byte %h with no item outstanding", fb);
        errors++;
        return;
      end
      eb = exp_bytes.pop_front();
      el = exp_last.pop_front();
      if (fb !== eb) begin
        $error("frame_byte: expected %h, actual %h", eb, fb);
        errors++;
      end
      if (lst !== el) begin
        $error("last: expected %b, actual %b", el, lst);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic [9:0] tempo_ms_i;
  logic       busy_o;
  logic       valid_o;
  logic [7:0] frame_byte_o;
  logic       last_o;

  frame_scoreboard sb;
  int          sender_idle_pct;
  int          items_sent;
  longint      cycle_count = 0;
  localparam longint CycleLimit = 400000;

  tempo_sysex_frame_builder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .tempo_ms_i   (tempo_ms_i),
    .valid_o      (valid_o),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Results are sampled at the rising edge, before any stimulus update lands.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_byte(frame_byte_o, last_o);
  end

  // Watchdog: ends the run as a failure once the cycle count passes the limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one tempo item, idling first at random, and holds start until the
  // block takes it. Start stays high when the next item follows directly, so
  // it is never lowered and raised in the same step.
  task automatic send_tempo(input logic [9:0] tempo);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    tempo_ms_i <= tempo;
    do @(posedge clk_i); while (busy_o);
    sb.note_tempo(tempo);
    items_sent++;
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (sb.exp_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0] directed[$];
    int         idle_plan[4];
    sb = new();
    items_sent      = 0;
    sender_idle_pct = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    tempo_ms_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero, the nominal limits, every single bit set, all ones
    // and values just around the range edges.
    directed = '{10'd0, 10'd1, 10'd20, 10'd1000, 10'd1023, 10'd19, 10'd1001,
                 10'd2, 10'd4, 10'd8, 10'd16, 10'd32, 10'd64, 10'd128,
                 10'd256, 10'd512, 10'd500, 10'd120, 10'd341, 10'd682};
    foreach (directed[i]) send_tempo(directed[i]);
    drain();

    // Random part in phases: no idling, frequent idling, light idling, then none.
    idle_plan = '{0, 61, 15, 0};
    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(9) < 8) send_tempo(10'($urandom_range(1000, 20)));
        else                       send_tempo(10'($urandom));
      end
      drain();
    end

    $display("Run covered %0d tempo items and %0d frame bytes across idle phases.",
             items_sent, sb.bytes_seen);
    if (sb.errors == 0 && sb.exp_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
